### rtl/lpm_pkg.sv
// Shared types, codes and widths for the IPv4 prefix lookup block.
package lpm_pkg;

	localparam int ADDR_W  = 32;
	localparam int PLEN_W  = 6;
	localparam int IDX_W   = 6;
	localparam int OWN_W   = 8;
	localparam int FUNC_W  = 2;
	localparam int KIND_W  = 2;

	localparam int ENTRIES_DEF = 64;
	// entry_index is 6 bits wide, so no slot at or above this is ever written
	localparam int MAX_SLOTS   = 64;

	localparam logic [PLEN_W-1:0] MAX_PLEN = 6'd32;

	// function codes on the input word
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

	// command kinds after classification
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] address;
		logic [PLEN_W-1:0] prefix;
		logic [IDX_W-1:0]  index;
		logic              valid;
		logic              reachable;
		logic [OWN_W-1:0]  owner;
	} cmd_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] index;
		logic [OWN_W-1:0] owner;
		logic             from_cache;
	} res_t;

endpackage

### rtl/lpm_front.sv
// Front end: accepts input words, classifies them and queues commands.
module lpm_front
	import lpm_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [FUNC_W-1:0] func,
	input  logic [ADDR_W-1:0] address,
	input  logic [PLEN_W-1:0] prefix_length,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic              entry_valid,
	input  logic              entry_reachable,
	input  logic [OWN_W-1:0]  owner_id,
	output logic              cmd_valid,
	output cmd_t              cmd,
	input  logic              cmd_pop
);

	cmd_t       fq_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       in_range;
	logic       do_push;
	logic       do_pop;

	assign in_range = 32'(entry_index) < ENTRIES;

	always_comb begin
		cls.address   = address;
		cls.prefix    = (prefix_length > MAX_PLEN) ? MAX_PLEN : prefix_length;
		cls.index     = entry_index;
		cls.valid     = entry_valid;
		cls.reachable = entry_reachable;
		cls.owner     = owner_id;
		unique case (func)
			FUNC_LOOKUP: cls.kind = KIND_LOOKUP;
			// a write to a slot outside the table changes nothing
			FUNC_WRITE:  cls.kind = in_range ? KIND_WRITE : KIND_NOP;
			FUNC_FLUSH:  cls.kind = KIND_FLUSH;
			default:     cls.kind = KIND_NOP;
		endcase
	end

	assign full      = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = fq_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) fq_q[wp_q] <= cls;
	end

endmodule

### rtl/lpm_back.sv
// Back end: table memory, two-slot answer cache and the sequential slot scan.
module lpm_back
	import lpm_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic oq_full,
	output logic oq_push,
	output res_t oq_data
);

	localparam int TBL_DEPTH = (ENTRIES < MAX_SLOTS) ? ENTRIES : MAX_SLOTS;
	localparam int AW        = $clog2(TBL_DEPTH);
	localparam int CW        = $clog2(TBL_DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [PLEN_W-1:0] prefix;
		logic [OWN_W-1:0]  owner;
		logic              reachable;
	} ent_t;

	ent_t              mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0] present_q;

	logic              st_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CW-1:0]     issue_q;
	logic              v_s1;
	ent_t              rd_s1;
	logic              pres_s1;
	logic [AW-1:0]     idx_s1;
	logic              found_q;
	logic [AW-1:0]     best_idx_q;
	logic [OWN_W-1:0]  best_own_q;

	logic [ADDR_W-1:0] c_addr_q  [2];
	logic [IDX_W-1:0]  c_idx_q   [2];
	logic [OWN_W-1:0]  c_own_q   [2];
	logic [1:0]        c_found_q;
	logic [1:0]        c_valid_q;
	logic              slot_q;

	logic              take;
	logic              hit0;
	logic              hit1;
	logic              wr_en;
	logic              rd_en;
	logic              match;
	logic              done;
	logic              n_found;
	logic [AW-1:0]     n_idx;
	logic [OWN_W-1:0]  n_own;
	ent_t              wr_ent;

	function automatic logic [ADDR_W-1:0] pmask(input logic [PLEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len == '0) m = '0;
		else           m = {ADDR_W{1'b1}} << (MAX_PLEN - len);
		return m;
	endfunction

	assign take    = (st_q == ST_IDLE) && cmd_valid && !oq_full;
	assign cmd_pop = take;
	assign hit0    = c_valid_q[0] && (c_addr_q[0] == cmd.address);
	assign hit1    = c_valid_q[1] && (c_addr_q[1] == cmd.address);
	assign wr_en   = take && (cmd.kind == KIND_WRITE);
	assign rd_en   = (st_q == ST_SCAN) && (issue_q < CW'(TBL_DEPTH));

	assign wr_ent.address   = cmd.address;
	assign wr_ent.prefix    = cmd.prefix;
	assign wr_ent.owner     = cmd.owner;
	assign wr_ent.reachable = cmd.reachable;

	// evaluate the slot read in the previous cycle
	assign match   = v_s1 && pres_s1 && (((addr_q ^ rd_s1.address) & pmask(rd_s1.prefix)) == '0);
	assign n_found = found_q || match;
	assign n_idx   = match ? idx_s1 : best_idx_q;
	assign n_own   = match ? rd_s1.owner : best_own_q;
	assign done    = v_s1 && ((match && rd_s1.reachable) || (idx_s1 == AW'(TBL_DEPTH - 1)));

	always_comb begin
		oq_push = 1'b0;
		oq_data = '0;
		if (st_q == ST_SCAN) begin
			oq_push = done;
			if (n_found) begin
				oq_data.found = 1'b1;
				oq_data.index = IDX_W'(n_idx);
				oq_data.owner = n_own;
			end
		end else if (take) begin
			priority if (cmd.kind == KIND_LOOKUP && hit0) begin
				oq_push            = 1'b1;
				oq_data.found      = c_found_q[0];
				oq_data.index      = c_idx_q[0];
				oq_data.owner      = c_own_q[0];
				oq_data.from_cache = 1'b1;
			end else if (cmd.kind == KIND_LOOKUP && hit1) begin
				oq_push            = 1'b1;
				oq_data.found      = c_found_q[1];
				oq_data.index      = c_idx_q[1];
				oq_data.owner      = c_own_q[1];
				oq_data.from_cache = 1'b1;
			end else if (cmd.kind == KIND_LOOKUP) begin
				oq_push = 1'b0;
			end else begin
				oq_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			issue_q    <= '0;
			v_s1       <= 1'b0;
			found_q    <= 1'b0;
			present_q  <= '0;
			c_found_q  <= '0;
			c_valid_q  <= '0;
			slot_q     <= 1'b0;
		end else begin
			if (st_q == ST_IDLE) begin
				v_s1 <= 1'b0;
				if (take) begin
					unique case (cmd.kind)
						KIND_LOOKUP: begin
							if (!hit0 && !hit1) begin
								st_q    <= ST_SCAN;
								issue_q <= '0;
								found_q <= 1'b0;
							end
						end
						KIND_WRITE: begin
							present_q[cmd.index[AW-1:0]] <= cmd.valid;
							c_valid_q <= '0;
						end
						KIND_FLUSH: c_valid_q <= '0;
						default: ;
					endcase
				end
			end else begin
				v_s1 <= rd_en && !done;
				if (rd_en) issue_q <= issue_q + 1'b1;
				found_q <= n_found;
				if (done) begin
					// store the answer in the other slot, then drop back to idle
					st_q              <= ST_IDLE;
					v_s1              <= 1'b0;
					slot_q            <= ~slot_q;
					c_valid_q[~slot_q] <= 1'b1;
					c_found_q[~slot_q] <= n_found;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) addr_q <= cmd.address;
		if (rd_en) begin
			pres_s1 <= present_q[issue_q[AW-1:0]];
			idx_s1  <= issue_q[AW-1:0];
		end
		if (st_q == ST_SCAN && match) begin
			best_idx_q <= idx_s1;
			best_own_q <= rd_s1.owner;
		end
		if (st_q == ST_SCAN && done) begin
			c_addr_q[~slot_q] <= addr_q;
			c_idx_q[~slot_q]  <= n_found ? IDX_W'(n_idx) : '0;
			c_own_q[~slot_q]  <= n_found ? n_own : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[cmd.index[AW-1:0]] <= wr_ent;
		if (rd_en) rd_s1 <= mem[issue_q[AW-1:0]];
	end

endmodule

### rtl/lpm_outq.sv
// Result queue: holds finished answers until the consumer pops them.
module lpm_outq
	import lpm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             oq_push,
	input  res_t             oq_data,
	output logic             oq_full,
	output logic             empty,
	input  logic             pop,
	output logic             found,
	output logic [IDX_W-1:0] match_index,
	output logic [OWN_W-1:0] match_owner,
	output logic             from_cache
);

	res_t       q_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;
	res_t       head;

	assign oq_full     = cnt_q == 2'd2;
	assign empty       = cnt_q == 2'd0;
	assign do_push     = oq_push && !oq_full;
	assign do_pop      = pop && !empty;
	assign head        = q_q[rp_q];
	assign found       = head.found;
	assign match_index = head.index;
	assign match_owner = head.owner;
	assign from_cache  = head.from_cache;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) q_q[wp_q] <= oq_data;
	end

endmodule

### rtl/ipv4_prefix_match_lookup.sv
// IPv4 longest-prefix lookup with a two-slot answer cache. Each word is a
// lookup, a table entry write, a cache flush or an unused code that does
// nothing; every word gives exactly one answer word. Writes, flushes and
// cache hits are answered without a table scan. A cache miss scans the table
// memory one slot per cycle from slot 0 through its single read port, and
// stops at the first match with a reachable owner or at the last slot. Slots
// at or above 64 cannot be addressed by entry_index and are never scanned.
// Two-word queues on the input and result sides buffer words; a full result
// queue stalls the back end, so the input queue can fill and raise full.
module ipv4_prefix_match_lookup
	import lpm_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [FUNC_W-1:0] func,
	input  logic [ADDR_W-1:0] address,
	input  logic [PLEN_W-1:0] prefix_length,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic              entry_valid,
	input  logic              entry_reachable,
	input  logic [OWN_W-1:0]  owner_id,
	output logic              empty,
	input  logic              pop,
	output logic              found,
	output logic [IDX_W-1:0]  match_index,
	output logic [OWN_W-1:0]  match_owner,
	output logic              from_cache
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic oq_full;
	logic oq_push;
	res_t oq_data;

	lpm_front #(.ENTRIES(ENTRIES)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.func           (func),
		.address        (address),
		.prefix_length  (prefix_length),
		.entry_index    (entry_index),
		.entry_valid    (entry_valid),
		.entry_reachable(entry_reachable),
		.owner_id       (owner_id),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop)
	);

	lpm_back #(.ENTRIES(ENTRIES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.oq_full  (oq_full),
		.oq_push  (oq_push),
		.oq_data  (oq_data)
	);

	lpm_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.oq_push    (oq_push),
		.oq_data    (oq_data),
		.oq_full    (oq_full),
		.empty      (empty),
		.pop        (pop),
		.found      (found),
		.match_index(match_index),
		.match_owner(match_owner),
		.from_cache (from_cache)
	);

endmodule

### tb/sv/tb_ipv4_prefix_match_lookup.sv
// Self-checking testbench for the IPv4 prefix lookup block and its answer cache.
module tb_ipv4_prefix_match_lookup;
	import lpm_pkg::*;

	localparam int SLOTS = ENTRIES_DEF;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int IDLE_PCT = 34;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 3 * (SLOTS + 2);

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] address;
		logic [PLEN_W-1:0] prefix;
		logic [IDX_W-1:0]  index;
		logic              valid;
		logic              reach;
		logic [OWN_W-1:0]  owner;
	} lookup_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [FUNC_W-1:0] func = FUNC_LOOKUP;
	logic [ADDR_W-1:0] address = '0;
	logic [PLEN_W-1:0] prefix_length = '0;
	logic [IDX_W-1:0]  entry_index = '0;
	logic              entry_valid = 1'b0;
	logic              entry_reachable = 1'b0;
	logic [OWN_W-1:0]  owner_id = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic              found;
	logic [IDX_W-1:0]  match_index;
	logic [OWN_W-1:0]  match_owner;
	logic              from_cache;

	// predicted table and cache contents
	logic [ADDR_W-1:0] tbl_addr [SLOTS];
	logic [PLEN_W-1:0] tbl_plen [SLOTS];
	logic [OWN_W-1:0]  tbl_owner [SLOTS];
	logic              tbl_reach [SLOTS];
	logic [SLOTS-1:0]  tbl_present = '0;
	logic [ADDR_W-1:0] cache_addr [2];
	logic [IDX_W-1:0]  cache_idx [2];
	logic              cache_found [2];
	logic [1:0]        cache_ok = 2'b00;
	logic              cache_sel = 1'b0;

	res_t              expected_answers [$];
	res_t              want;
	int                error_count = 0;
	int                items_sent = 0;
	int                stall_cycles = 0;
	logic              no_idle = 1'b0;
	logic [ADDR_W-1:0] recent_addr [4] = '{default: '0};
	logic [1:0]        recent_ptr = '0;

	ipv4_prefix_match_lookup u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.address(address),
		.prefix_length(prefix_length),
		.entry_index(entry_index),
		.entry_valid(entry_valid),
		.entry_reachable(entry_reachable),
		.owner_id(owner_id),
		.empty(empty),
		.pop(pop),
		.found(found),
		.match_index(match_index),
		.match_owner(match_owner),
		.from_cache(from_cache)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want_val);
		$display("ERROR: %s got %0h expected %0h", what, got, want_val);
		error_count++;
	endtask

	function automatic logic [ADDR_W-1:0] net_mask(input logic [PLEN_W-1:0] len);
		if (len == 0)
			return '0;
		return {ADDR_W{1'b1}} << (ADDR_W - int'(len));
	endfunction

	function automatic res_t predict_answer(input lookup_word_t w);
		res_t             ans;
		logic             hit;
		logic             hit_found;
		logic [IDX_W-1:0] hit_idx;
		logic             done;
		logic [PLEN_W-1:0] len;
		ans = '0;
		hit = 1'b0;
		hit_found = 1'b0;
		hit_idx = '0;
		done = 1'b0;
		case (w.func)
			FUNC_LOOKUP: begin
				for (int i = 0; i < 2; i++) begin
					if (!hit && cache_ok[i] && cache_addr[i] == w.address) begin
						hit = 1'b1;
						hit_found = cache_found[i];
						hit_idx = cache_idx[i];
					end
				end
				if (!hit) begin
					// first reachable match wins, else the last match seen
					for (int i = 0; i < SLOTS; i++) begin
						if (!done && tbl_present[i] &&
								((w.address ^ tbl_addr[i]) & net_mask(tbl_plen[i])) == '0) begin
							hit_found = 1'b1;
							hit_idx = IDX_W'(i);
							done = tbl_reach[i];
						end
					end
					cache_sel = ~cache_sel;
					cache_addr[cache_sel] = w.address;
					cache_idx[cache_sel] = hit_idx;
					cache_found[cache_sel] = hit_found;
					cache_ok[cache_sel] = 1'b1;
				end
				ans.found = hit_found;
				ans.index = hit_found ? hit_idx : '0;
				ans.owner = hit_found ? tbl_owner[hit_idx] : '0;
				ans.from_cache = hit;
			end
			FUNC_WRITE: begin
				len = (w.prefix > MAX_PLEN) ? MAX_PLEN : w.prefix;
				tbl_addr[w.index] = w.address;
				tbl_plen[w.index] = len;
				tbl_present[w.index] = w.valid;
				tbl_reach[w.index] = w.reach;
				tbl_owner[w.index] = w.owner;
				cache_ok = 2'b00;
			end
			FUNC_FLUSH: cache_ok = 2'b00;
			default: ;
		endcase
		return ans;
	endfunction

	function automatic lookup_word_t random_word(input logic [FUNC_W-1:0] f);
		lookup_word_t w;
		w.func = f;
		w.address = $urandom;
		w.prefix = PLEN_W'($urandom_range(0, 63));
		w.index = IDX_W'($urandom_range(0, SLOTS - 1));
		w.valid = 1'($urandom_range(0, 1));
		w.reach = 1'($urandom_range(0, 1));
		w.owner = OWN_W'($urandom_range(0, 255));
		return w;
	endfunction

	// leaves push high; the next send or a drain decides what follows
	task automatic send_word(input lookup_word_t w);
		if (!no_idle) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push <= 1'b1;
		func <= w.func;
		address <= w.address;
		prefix_length <= w.prefix;
		entry_index <= w.index;
		entry_valid <= w.valid;
		entry_reachable <= w.reach;
		owner_id <= w.owner;
		do @(posedge clk); while (full);
		expected_answers.push_back(predict_answer(w));
		if (w.func != FUNC_UNUSED)
			items_sent++;
		if (w.func == FUNC_LOOKUP) begin
			recent_addr[recent_ptr] = w.address;
			recent_ptr++;
		end
	endtask

	task automatic send_lookup(input logic [ADDR_W-1:0] a);
		lookup_word_t w;
		w = random_word(FUNC_LOOKUP);
		w.address = a;
		send_word(w);
	endtask

	task automatic send_entry(input int slot, input logic [ADDR_W-1:0] a,
			input logic [PLEN_W-1:0] len, input logic valid, input logic reach,
			input logic [OWN_W-1:0] owner);
		lookup_word_t w;
		w.func = FUNC_WRITE;
		w.address = a;
		w.prefix = len;
		w.index = IDX_W'(slot);
		w.valid = valid;
		w.reach = reach;
		w.owner = owner;
		send_word(w);
	endtask

	task automatic wait_drain();
		push <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
	endtask

	// sorted nested-prefix tables, then mostly lookups aimed at them
	task automatic run_random_mix(input int target);
		int                r;
		int                s;
		int                k;
		int                slot;
		int                pl;
		int                tries;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] m;
		lookup_word_t      w;
		while (items_sent < target) begin
			k = $urandom_range(2, 12);
			slot = $urandom_range(0, 48);
			pl = $urandom_range(16, 32);
			base = $urandom;
			for (int j = 0; j < k && slot < SLOTS; j++) begin
				send_entry(slot, base ^ ($urandom >> $urandom_range(8, 31)), PLEN_W'(pl),
					1'b1, $urandom_range(0, 3) != 0, OWN_W'($urandom_range(0, 255)));
				slot += $urandom_range(1, 4);
				pl = (pl > 6) ? pl - $urandom_range(0, 6) : 0;
			end
			repeat ($urandom_range(20, 60)) begin
				r = $urandom_range(99);
				s = $urandom_range(0, SLOTS - 1);
				tries = 0;
				while (!tbl_present[s] && tries < 8) begin
					s = $urandom_range(0, SLOTS - 1);
					tries++;
				end
				if (r < 55) begin
					if (tbl_present[s]) begin
						m = net_mask(tbl_plen[s]);
						send_lookup((tbl_addr[s] & m) | ($urandom & ~m));
					end else begin
						send_lookup($urandom);
					end
				end else if (r < 75) begin
					send_lookup(recent_addr[$urandom_range(0, 3)]);
				end else if (r < 85) begin
					send_lookup($urandom);
				end else if (r < 91 && tbl_present[s]) begin
					// flip reachability of a live entry
					send_entry(s, tbl_addr[s], tbl_plen[s], 1'b1, ~tbl_reach[s], tbl_owner[s]);
				end else if (r < 94) begin
					w = random_word(FUNC_WRITE);
					w.valid = 1'b0;
					send_word(w);
				end else if (r < 97) begin
					send_word(random_word(FUNC_FLUSH));
				end else if (r < 98) begin
					send_word(random_word(FUNC_UNUSED));
				end else begin
					send_word(random_word(FUNC_WRITE));
				end
			end
		end
	endtask

	task automatic test_empty_table();
		send_lookup(32'h0000_0000);
		send_lookup(32'h0000_0000);
		send_lookup(32'hFFFF_FFFF);
		send_word(random_word(FUNC_UNUSED));
		send_word(random_word(FUNC_FLUSH));
		send_lookup(32'hFFFF_FFFF);
	endtask

	task automatic test_priority_rules();
		// prefix above 32 saturates to a host route
		send_entry(0, 32'hC0A8_0101, 6'd63, 1'b1, 1'b1, 8'hFF);
		send_entry(1, 32'hC0A8_0100, 6'd24, 1'b1, 1'b0, 8'h01);
		send_entry(2, 32'hC0A8_0000, 6'd16, 1'b1, 1'b0, 8'h02);
		send_entry(SLOTS - 1, 32'hFFFF_FFFF, 6'd0, 1'b1, 1'b1, 8'h00);
		send_lookup(32'hC0A8_0101);
		send_lookup(32'hC0A8_01FE);
		// no reachable owner left: last match wins
		send_entry(SLOTS - 1, 32'hFFFF_FFFF, 6'd0, 1'b1, 1'b0, 8'h00);
		send_lookup(32'hC0A8_01FE);
		send_lookup(32'hC0A8_01FE);
		send_lookup(32'h0000_0000);
		send_lookup(32'hC0A8_0101);
		send_lookup(32'hC0A8_01FE);
		send_entry(SLOTS - 1, 32'h0000_0000, 6'd0, 1'b0, 1'b0, 8'h00);
		send_lookup(32'h0000_0000);
		send_lookup(32'h0000_0000);
		send_entry(1, 32'hC0A8_0100, 6'd24, 1'b1, 1'b1, 8'h01);
		send_lookup(32'hC0A8_01FE);
		send_lookup(32'hC0A8_01FE);
		send_word(random_word(FUNC_FLUSH));
		send_lookup(32'hC0A8_01FE);
	endtask

	task automatic test_random_traffic();
		run_random_mix(items_sent + 900);
	endtask

	task automatic test_no_idle_stretch();
		no_idle <= 1'b1;
		run_random_mix(items_sent + 300);
		no_idle <= 1'b0;
	endtask

	task automatic test_pause_for_drain();
		run_random_mix(items_sent + 60);
		wait_drain();
		run_random_mix(items_sent + 60);
		wait_drain();
		run_random_mix(items_sent + 60);
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("answer with none pending", 32'({found, match_index}), 0);
			end else begin
				want = expected_answers.pop_front();
				if (found !== want.found)
					report_mismatch("found", 32'(found), 32'(want.found));
				if (match_index !== want.index)
					report_mismatch("match_index", 32'(match_index), 32'(want.index));
				if (match_owner !== want.owner)
					report_mismatch("match_owner", 32'(match_owner), 32'(want.owner));
				if (from_cache !== want.from_cache)
					report_mismatch("from_cache", 32'(from_cache), 32'(want.from_cache));
			end
		end
		pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		wait_drain();
		test_priority_rules();
		wait_drain();
		test_random_traffic();
		test_no_idle_stretch();
		test_pause_for_drain();
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_answers.size() != 0)
			report_mismatch("answers left pending", expected_answers.size(), 0);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### ipv4_prefix_match_lookup.f
rtl/lpm_pkg.sv
rtl/lpm_front.sv
rtl/lpm_back.sv
rtl/lpm_outq.sv
rtl/ipv4_prefix_match_lookup.sv
tb/sv/tb_ipv4_prefix_match_lookup.sv
